// ===== src/assert_macros.svh =====
// assertion helpers used by the checker file dnsp_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent property on a clock, disabled while reset is low
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ASSERT_PROP(label, clk, rst_n, !(cond), msg)

`endif

// ===== src/dnsp_pkg.sv =====
`default_nettype none

package dnsp_pkg;

  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned OFF_ID_HI    = 0;
  localparam int unsigned OFF_ID_LO    = 1;
  localparam int unsigned OFF_QD_HI    = 4;
  localparam int unsigned OFF_QD_LO    = 5;
  localparam int unsigned OFF_AN_HI    = 6;
  localparam int unsigned OFF_AN_LO    = 7;
  localparam int unsigned OFF_HDR_END  = 11;

  localparam logic [15:0] EXPECTED_ID_RESET = 16'h4F53;
  localparam logic [7:0]  PTR_MASK          = 8'hC0;
  localparam logic [15:0] TYPE_A            = 16'd1;
  localparam logic [15:0] IPV4_LEN          = 16'd4;

  localparam logic [3:0] FI_TYPE_HI = 4'd0;
  localparam logic [3:0] FI_TYPE_LO = 4'd1;
  localparam logic [3:0] FI_LEN_HI  = 4'd8;
  localparam logic [3:0] FI_LEN_LO  = 4'd9;
  localparam logic [3:0] FI_ADDR_N  = 4'd4;

  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_BADID    = 3'd2;
  localparam logic [2:0] ST_NOANSWER = 3'd3;
  localparam logic [2:0] ST_NOA      = 3'd4;

  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_QNAME  = 6'b000010,
    PH_ANAME  = 6'b000100,
    PH_AFIXED = 6'b001000,
    PH_ADATA  = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_e;

  typedef struct packed {
    logic        valid;
    logic [2:0]  status;
    logic [31:0] address;
  } result_t;

endpackage

`default_nettype wire

// ===== src/dns_response_a_record_parser.sv =====
// latency: the status word appears in the cycle after the last byte is accepted
// throughput: one byte per cycle while the input is not stalled, set by the single parse step into the state registers
// input stalls only while a finished status word waits on a stalled output
// reset clears the parse state and output register, expected id returns to 0x4F53
`default_nettype none

module dns_response_a_record_parser #(
  parameter int unsigned MAX_PACKET_BYTES = 512
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [31:0]      address_o
);

  logic [15:0]       expected_id_q;
  logic              out_valid_q;
  logic [2:0]        status_q;
  logic [31:0]       address_q;
  logic              accept;
  dnsp_pkg::result_t result;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_id_q <= dnsp_pkg::EXPECTED_ID_RESET;
    end else if (cfg_we_i) begin
      expected_id_q <= cfg_wdata_i;
    end
  end

  dnsp_parser #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (accept),
    .rx_byte_i    (rx_byte_i),
    .last_byte_i  (last_byte_i),
    .expected_id_i(expected_id_q),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (result.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q  <= '0;
      address_q <= '0;
    end else if (result.valid) begin
      status_q  <= result.status;
      address_q <= result.address;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign address_o   = address_q;

endmodule

`default_nettype wire

// ===== src/dnsp_parser.sv =====
`default_nettype none

module dnsp_parser #(
  parameter int unsigned MAX_PACKET_BYTES = 512
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             byte_valid_i,
  input  wire logic [7:0]       rx_byte_i,
  input  wire logic             last_byte_i,
  input  wire logic [15:0]      expected_id_i,
  output dnsp_pkg::result_t     result_o
);

  localparam int unsigned OffW = $clog2(MAX_PACKET_BYTES + 1);

  logic [OffW-1:0]   off_q, off_d;
  dnsp_pkg::phase_e  phase_q, phase_d;
  logic [15:0]       hdr_id_q, hdr_id_d;
  logic [15:0]       q_left_q, q_left_d;
  logic [15:0]       a_left_q, a_left_d;
  logic [15:0]       skip_q, skip_d;
  logic [3:0]        fi_q, fi_d;
  logic [15:0]       rtype_q, rtype_d;
  logic [15:0]       rlen_q, rlen_d;
  logic [31:0]       accum_q, accum_d;
  logic [2:0]        outcome_q, outcome_d;
  logic              name_end;
  logic [15:0]       len_full;
  logic [15:0]       q_dec;
  logic [15:0]       a_dec;
  logic [3:0]        fi_inc;
  logic [2:0]        status;

  assign name_end = (rx_byte_i == 8'h00) ||
                    ((rx_byte_i & dnsp_pkg::PTR_MASK) == dnsp_pkg::PTR_MASK);
  assign len_full = {rlen_q[15:8], rx_byte_i};
  assign q_dec    = q_left_q - 16'd1;
  assign a_dec    = a_left_q - 16'd1;
  assign fi_inc   = fi_q + 4'd1;

  always_comb begin
    off_d     = off_q;
    phase_d   = phase_q;
    hdr_id_d  = hdr_id_q;
    q_left_d  = q_left_q;
    a_left_d  = a_left_q;
    skip_d    = skip_q;
    fi_d      = fi_q;
    rtype_d   = rtype_q;
    rlen_d    = rlen_q;
    accum_d   = accum_q;
    outcome_d = outcome_q;
    if (off_q < OffW'(MAX_PACKET_BYTES)) begin
      off_d = off_q + OffW'(1);
      if (phase_q == dnsp_pkg::PH_HEADER) begin
        if (off_q == OffW'(dnsp_pkg::OFF_ID_HI)) hdr_id_d[15:8] = rx_byte_i;
        if (off_q == OffW'(dnsp_pkg::OFF_ID_LO)) hdr_id_d[7:0]  = rx_byte_i;
        if (off_q == OffW'(dnsp_pkg::OFF_QD_HI)) q_left_d[15:8] = rx_byte_i;
        if (off_q == OffW'(dnsp_pkg::OFF_QD_LO)) q_left_d[7:0]  = rx_byte_i;
        if (off_q == OffW'(dnsp_pkg::OFF_AN_HI)) a_left_d[15:8] = rx_byte_i;
        if (off_q == OffW'(dnsp_pkg::OFF_AN_LO)) a_left_d[7:0]  = rx_byte_i;
        if (off_q == OffW'(dnsp_pkg::OFF_HDR_END)) begin
          if (hdr_id_q != expected_id_i) begin
            outcome_d = dnsp_pkg::ST_BADID;
            phase_d   = dnsp_pkg::PH_DONE;
          end else if (a_left_q == 16'd0) begin
            outcome_d = dnsp_pkg::ST_NOANSWER;
            phase_d   = dnsp_pkg::PH_DONE;
          end else begin
            outcome_d = dnsp_pkg::ST_NOA;
            phase_d   = (q_left_q != 16'd0) ? dnsp_pkg::PH_QNAME : dnsp_pkg::PH_ANAME;
          end
        end
      end else if (phase_q != dnsp_pkg::PH_DONE) begin
        if (skip_q != 16'd0) begin
          skip_d = skip_q - 16'd1;
        end else begin
          unique case (phase_q)
            dnsp_pkg::PH_QNAME: begin
              if (name_end) begin
                skip_d   = (rx_byte_i == 8'h00) ? 16'd4 : 16'd5;
                q_left_d = q_dec;
                if (q_dec != 16'd0)         phase_d = dnsp_pkg::PH_QNAME;
                else if (a_left_q != 16'd0) phase_d = dnsp_pkg::PH_ANAME;
                else                        phase_d = dnsp_pkg::PH_DONE;
              end else begin
                skip_d = {8'h00, rx_byte_i};
              end
            end
            dnsp_pkg::PH_ANAME: begin
              if (name_end) begin
                skip_d  = (rx_byte_i == 8'h00) ? 16'd0 : 16'd1;
                fi_d    = 4'd0;
                phase_d = dnsp_pkg::PH_AFIXED;
              end else begin
                skip_d = {8'h00, rx_byte_i};
              end
            end
            dnsp_pkg::PH_AFIXED: begin
              if (fi_q == dnsp_pkg::FI_TYPE_HI) rtype_d = {rx_byte_i, 8'h00};
              if (fi_q == dnsp_pkg::FI_TYPE_LO) rtype_d = rtype_q | {8'h00, rx_byte_i};
              if (fi_q == dnsp_pkg::FI_LEN_HI)  rlen_d  = {rx_byte_i, 8'h00};
              if (fi_q == dnsp_pkg::FI_LEN_LO) begin
                rlen_d = len_full;
                fi_d   = 4'd0;
                if (rtype_q == dnsp_pkg::TYPE_A && len_full == dnsp_pkg::IPV4_LEN) begin
                  accum_d = 32'd0;
                  phase_d = dnsp_pkg::PH_ADATA;
                end else begin
                  skip_d   = len_full;
                  a_left_d = a_dec;
                  phase_d  = (a_dec != 16'd0) ? dnsp_pkg::PH_ANAME : dnsp_pkg::PH_DONE;
                end
              end else begin
                fi_d = fi_inc;
              end
            end
            dnsp_pkg::PH_ADATA: begin
              accum_d = {accum_q[23:0], rx_byte_i};
              fi_d    = fi_inc;
              if (fi_inc >= dnsp_pkg::FI_ADDR_N) begin
                outcome_d = dnsp_pkg::ST_FOUND;
                phase_d   = dnsp_pkg::PH_DONE;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  assign status = (off_d < OffW'(dnsp_pkg::HEADER_BYTES)) ? dnsp_pkg::ST_SHORT : outcome_d;

  always_comb begin
    result_o.valid   = byte_valid_i && last_byte_i;
    result_o.status  = status;
    result_o.address = (status == dnsp_pkg::ST_FOUND) ? accum_d : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q     <= '0;
      phase_q   <= dnsp_pkg::PH_HEADER;
      hdr_id_q  <= '0;
      q_left_q  <= '0;
      a_left_q  <= '0;
      skip_q    <= '0;
      fi_q      <= '0;
      rtype_q   <= '0;
      rlen_q    <= '0;
      accum_q   <= '0;
      outcome_q <= dnsp_pkg::ST_NOA;
    end else if (byte_valid_i) begin
      if (last_byte_i) begin
        // packet done, start afresh
        off_q     <= '0;
        phase_q   <= dnsp_pkg::PH_HEADER;
        hdr_id_q  <= '0;
        q_left_q  <= '0;
        a_left_q  <= '0;
        skip_q    <= '0;
        fi_q      <= '0;
        rtype_q   <= '0;
        rlen_q    <= '0;
        accum_q   <= '0;
        outcome_q <= dnsp_pkg::ST_NOA;
      end else begin
        off_q     <= off_d;
        phase_q   <= phase_d;
        hdr_id_q  <= hdr_id_d;
        q_left_q  <= q_left_d;
        a_left_q  <= a_left_d;
        skip_q    <= skip_d;
        fi_q      <= fi_d;
        rtype_q   <= rtype_d;
        rlen_q    <= rlen_d;
        accum_q   <= accum_d;
        outcome_q <= outcome_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/dnsp_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module dnsp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        last_byte_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [2:0]  status_o,
  input wire logic [31:0] address_o
);

  logic in_take;
  logic out_wait;
  logic stall_idle;

  assign in_take    = in_valid_i && !in_stall_o;
  assign out_wait   = out_valid_o && out_stall_i;
  assign stall_idle = in_stall_o && !out_valid_o;

  property p_out_hold;
    out_wait |=> out_valid_o && $stable(status_o) && $stable(address_o);
  endproperty

  property p_last_gives_word;
    in_take && last_byte_i |=> out_valid_o;
  endproperty

  property p_status_range;
    out_valid_o |-> status_o <= dnsp_pkg::ST_NOA;
  endproperty

  property p_addr_zero;
    out_valid_o && status_o != dnsp_pkg::ST_FOUND |-> address_o == 32'd0;
  endproperty

  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, p_out_hold, "stalled word changed")
  `ASSERT_PROP(a_last_gives_word, clk_i, rst_ni, p_last_gives_word, "no word after last byte")
  `ASSERT_PROP(a_status_range, clk_i, rst_ni, p_status_range, "status code out of range")
  `ASSERT_PROP(a_addr_zero, clk_i, rst_ni, p_addr_zero, "address set without a found status")
  `ASSERT_NEVER(a_stall_cause, clk_i, rst_ni, stall_idle, "input stalled with output empty")

endmodule

bind dns_response_a_record_parser dnsp_checker u_dnsp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .last_byte_i(last_byte_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .status_o   (status_o),
  .address_o  (address_o)
);

`default_nettype wire
